@@ hw/rtl/vlfd_pkg.sv @@
// Package for the varint length frame deframer.
// Holds the phase and result kind codes, the varint limit and the shared structs.
// No dependencies.
package vlfd_pkg;

  localparam int unsigned VarintMaxBytes = 5;
  localparam int unsigned CountW         = 3;

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_ID      = 3'd1,
    PH_DLEN    = 3'd2,
    PH_BODY_ID = 3'd3,
    PH_BODY    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // Status of the varint in progress for the word presented this cycle.
  typedef struct packed {
    logic              done;
    logic [31:0]       value;
    logic [CountW-1:0] count;
  } varint_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] msg_id;
    logic        body_compressed;
    logic [31:0] body_length;
    logic [31:0] inflated_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/vlfd_varint.sv @@
// Little-endian base-128 varint accumulator, kept to 32 bits.
// Depends on vlfd_pkg.
module vlfd_varint (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       byte_i,
  output vlfd_pkg::varint_t status_o
);
  import vlfd_pkg::*;

  logic [31:0]       accum_q, accum_d;
  logic [CountW-1:0] count_q, count_d;
  logic [5:0]        shamt;
  logic [31:0]       sum;
  logic [CountW-1:0] count_inc;
  logic              done;

  always_comb begin
    shamt     = 6'(count_q) * 6'd7;
    sum       = accum_q + (32'(byte_i[6:0]) << shamt);
    count_inc = count_q + CountW'(1);
    done      = !byte_i[7] || (count_inc >= CountW'(VarintMaxBytes));
  end

  assign status_o = '{done: done, value: sum, count: count_inc};

  always_comb begin
    accum_d = accum_q;
    count_d = count_q;
    if (take_i) begin
      if (done) begin
        accum_d = '0;
        count_d = '0;
      end else begin
        accum_d = sum;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      count_q <= '0;
    end else begin
      accum_q <= accum_d;
      count_q <= count_d;
    end
  end

endmodule

@@ hw/rtl/varint_length_frame_deframer_top.sv @@
// Varint length frame deframer: splits a byte stream into frame header, payload, empty and error words.
// Output: a result word is registered and presented in the cycle after the input word that causes it.
// Throughput: one input word per cycle unless the output stalls, set by the single frame state update per word.
// Reset: asynchronous, active low; idle, waiting for a frame length, compression off.
// Depends on vlfd_pkg and vlfd_varint.
module varint_length_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [31:0] msg_id_o,
  output logic        body_compressed_o,
  output logic [31:0] body_length_o,
  output logic [31:0] inflated_length_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);
  import vlfd_pkg::*;

  logic        comp_q;
  phase_e      phase_q, phase_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic        res_valid;
  logic        in_fire;
  logic        take;
  varint_t     vi;
  logic        bl_short;
  logic [31:0] bl_rem;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign take       = in_fire && (phase_q != PH_BODY);

  vlfd_varint u_varint (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (rx_byte_i),
    .status_o (vi)
  );

  assign bl_short = bytes_left_q < 32'(vi.count);
  assign bl_rem   = bytes_left_q - 32'(vi.count);

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    if (in_fire) begin
      case (phase_q)
        PH_ID, PH_BODY_ID: begin
          if (vi.done) begin
            if (bl_short) begin
              phase_d      = PH_LEN;
              bytes_left_d = '0;
            end else begin
              phase_d      = (bl_rem != '0) ? PH_BODY : PH_LEN;
              bytes_left_d = bl_rem;
            end
          end
        end
        PH_DLEN: begin
          if (vi.done) begin
            if (bl_short) begin
              phase_d      = PH_LEN;
              bytes_left_d = '0;
            end else if (vi.value != '0) begin
              phase_d      = (bl_rem != '0) ? PH_BODY : PH_LEN;
              bytes_left_d = bl_rem;
            end else if (bl_rem == '0) begin
              phase_d      = PH_LEN;
              bytes_left_d = '0;
            end else begin
              phase_d      = PH_BODY_ID;
              bytes_left_d = bl_rem;
            end
          end
        end
        PH_BODY: begin
          if (bytes_left_q <= 32'd1) begin
            phase_d      = PH_LEN;
            bytes_left_d = '0;
          end else begin
            bytes_left_d = bytes_left_q - 32'd1;
          end
        end
        default: begin
          phase_d = PH_LEN;
          if (vi.done) begin
            bytes_left_d = vi.value;
            if (vi.value != '0) begin
              phase_d = comp_q ? PH_DLEN : PH_ID;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res_d     = '0;
    case (phase_q)
      PH_ID, PH_BODY_ID: begin
        if (vi.done) begin
          res_valid = 1'b1;
          if (bl_short) begin
            res_d.kind = KIND_ERROR;
            res_d.last = 1'b1;
          end else begin
            res_d.kind        = KIND_HEADER;
            res_d.msg_id      = vi.value;
            res_d.body_length = bl_rem;
            res_d.last        = (bl_rem == '0);
          end
        end
      end
      PH_DLEN: begin
        if (vi.done) begin
          if (bl_short) begin
            res_valid  = 1'b1;
            res_d.kind = KIND_ERROR;
            res_d.last = 1'b1;
          end else if (vi.value != '0) begin
            res_valid             = 1'b1;
            res_d.kind            = KIND_HEADER;
            res_d.body_compressed = 1'b1;
            res_d.body_length     = bl_rem;
            res_d.inflated_length = vi.value;
            res_d.last            = (bl_rem == '0);
          end else if (bl_rem == '0) begin
            res_valid  = 1'b1;
            res_d.kind = KIND_ERROR;
            res_d.last = 1'b1;
          end
        end
      end
      PH_BODY: begin
        res_valid       = 1'b1;
        res_d.kind      = KIND_DATA;
        res_d.data_byte = rx_byte_i;
        res_d.last      = (bytes_left_q <= 32'd1);
      end
      default: begin
        if (vi.done && (vi.value == '0)) begin
          res_valid  = 1'b1;
          res_d.kind = KIND_EMPTY;
          res_d.last = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q       <= 1'b0;
      phase_q      <= PH_LEN;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        comp_q <= cfg_wdata_i;
      end
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = res_q.kind;
  assign msg_id_o          = res_q.msg_id;
  assign body_compressed_o = res_q.body_compressed;
  assign body_length_o     = res_q.body_length;
  assign inflated_length_o = res_q.inflated_length;
  assign data_byte_o       = res_q.data_byte;
  assign last_o            = res_q.last;

  a_body_gives_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (phase_q == PH_BODY) |=> out_valid_o && (out_kind_o == KIND_DATA))
    else $error("payload word did not produce a data result");

  a_body_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (bytes_left_q != '0))
    else $error("payload phase with no bytes left");

  a_end_kinds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_kind_o == KIND_ERROR) || (out_kind_o == KIND_EMPTY)) |-> last_o)
    else $error("error or empty frame result without last");

endmodule

@@ dv/varint_length_frame_deframer_top_test.sv @@
// Testbench for varint_length_frame_deframer_top: directed and random byte streams in plain and
// compressed frame format, each output word checked against a behavioural frame splitter.
// Depends on vlfd_pkg and the deframer RTL.
module varint_length_frame_deframer_top_test;
  import vlfd_pkg::*;

  localparam int unsigned StallLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  out_kind_o;
  logic [31:0] msg_id_o;
  logic        body_compressed_o;
  logic [31:0] body_length_o;
  logic [31:0] inflated_length_o;
  logic [7:0]  data_byte_o;
  logic        last_o;

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 58;
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Behavioural frame splitter state.
  phase_e      frame_phase = PH_LEN;
  logic [31:0] varint_acc = '0;
  logic [2:0]  varint_count = '0;
  logic [31:0] body_left = '0;
  logic        compressed_mode = 1'b0;
  result_t     expected_words[$];

  varint_length_frame_deframer_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_kind_o       (out_kind_o),
    .msg_id_o         (msg_id_o),
    .body_compressed_o(body_compressed_o),
    .body_length_o    (body_length_o),
    .inflated_length_o(inflated_length_o),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void emit_word(input kind_e kind, input logic [31:0] id, input logic comp,
                                    input logic [31:0] blen, input logic [31:0] ilen,
                                    input logic [7:0] data, input logic last);
    result_t w;
    w.kind            = kind;
    w.msg_id          = id;
    w.body_compressed = comp;
    w.body_length     = blen;
    w.inflated_length = ilen;
    w.data_byte       = data;
    w.last            = last;
    expected_words.push_back(w);
  endfunction

  function automatic void frame_error();
    frame_phase = PH_LEN;
    body_left   = '0;
    emit_word(KIND_ERROR, '0, 1'b0, '0, '0, 8'h00, 1'b1);
  endfunction

  function automatic void emit_header(input logic [31:0] id, input logic comp,
                                      input logic [31:0] n, input logic [31:0] ilen);
    body_left   = n;
    frame_phase = (n != 0) ? PH_BODY : PH_LEN;
    emit_word(KIND_HEADER, id, comp, n, ilen, 8'h00, 1'(n == 0));
  endfunction

  function automatic logic take_varint_byte(input logic [7:0] b, output logic [31:0] value,
                                            output logic [2:0] nbytes);
    varint_acc += 32'(b[6:0]) << (7 * varint_count);
    varint_count++;
    value  = varint_acc;
    nbytes = varint_count;
    if (b[7] && varint_count < VarintMaxBytes) return 1'b0;
    varint_acc   = '0;
    varint_count = '0;
    return 1'b1;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [31:0] v;
    logic [2:0]  c;
    case (frame_phase)
      PH_ID, PH_BODY_ID: begin
        if (take_varint_byte(b, v, c)) begin
          if (body_left < c) frame_error();
          else emit_header(v, 1'b0, body_left - c, '0);
        end
      end
      PH_DLEN: begin
        if (take_varint_byte(b, v, c)) begin
          if (body_left < c) frame_error();
          else if (v != 0) emit_header('0, 1'b1, body_left - c, v);
          else if (body_left == c) frame_error();
          else begin
            body_left -= c;
            frame_phase = PH_BODY_ID;
          end
        end
      end
      PH_BODY: begin
        emit_word(KIND_DATA, '0, 1'b0, '0, '0, b, 1'(body_left <= 1));
        body_left = (body_left <= 1) ? '0 : body_left - 1;
        if (body_left == 0) frame_phase = PH_LEN;
      end
      default: begin
        frame_phase = PH_LEN;
        if (take_varint_byte(b, v, c)) begin
          if (v == 0) begin
            body_left = '0;
            emit_word(KIND_EMPTY, '0, 1'b0, '0, '0, 8'h00, 1'b1);
          end else begin
            body_left   = v;
            frame_phase = compressed_mode ? PH_DLEN : PH_ID;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("out_kind: expected no word, actual %0d", out_kind_o);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("out_kind", 32'(want.kind), 32'(out_kind_o));
        check_field("msg_id", want.msg_id, msg_id_o);
        check_field("body_compressed", 32'(want.body_compressed), 32'(body_compressed_o));
        check_field("body_length", want.body_length, body_length_o);
        check_field("inflated_length", want.inflated_length, inflated_length_o);
        check_field("data_byte", 32'(want.data_byte), 32'(data_byte_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Bits beyond the 32-bit value in a fifth byte are filled at random, as is its bit 7.
  task automatic send_varint(input logic [31:0] v, input int unsigned w);
    logic [7:0] b;
    for (int unsigned i = 0; i < w; i++) begin
      if (i == VarintMaxBytes - 1) b = {1'($urandom), 3'($urandom), v[31:28]};
      else b = {1'(i + 1 < w), 7'(v >> (7 * i))};
      send_byte(b);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic on);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    compressed_mode = on;
    cfg_we <= 1'b0;
  endtask

  // Brings the stream back to a frame boundary; payloads here are always short.
  task automatic resync_stream();
    while (frame_phase != PH_LEN || varint_count != 0)
      send_byte(frame_phase == PH_BODY ? 8'($urandom) : 8'h00);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(3))
      0: return $urandom_range(127);
      1: return $urandom_range(16383);
      2: return $urandom;
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic int unsigned pick_width(input logic [31:0] v);
    int unsigned w;
    w = 1;
    while (w < VarintMaxBytes && (v >> (7 * w)) != 0) w++;
    if ($urandom_range(3) == 0) w = $urandom_range(VarintMaxBytes, w);
    return w;
  endfunction

  task automatic send_random_frame();
    logic [31:0] id;
    logic [31:0] dlen;
    int unsigned n, id_w, dlen_w, len, pick;
    pick = $urandom_range(99);
    n    = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    id   = random_word();
    id_w = pick_width(id);
    dlen = random_word();
    if (pick < 72) begin
      if (!compressed_mode) begin
        send_varint(id_w + n, pick_width(id_w + n));
        send_varint(id, id_w);
      end else if (dlen != 0 && $urandom_range(1)) begin
        dlen_w = pick_width(dlen);
        send_varint(dlen_w + n, pick_width(dlen_w + n));
        send_varint(dlen, dlen_w);
      end else begin
        dlen_w = pick_width(0);
        len    = dlen_w + id_w + n;
        send_varint(len, pick_width(len));
        send_varint(0, dlen_w);
        send_varint(id, id_w);
      end
      send_payload(n);
    end else if (pick < 84) begin
      id_w = $urandom_range(VarintMaxBytes, (id_w < 2) ? 2 : id_w);
      case (compressed_mode ? $urandom_range(2) : 0)
        0: begin
          len = $urandom_range(1, id_w - 1);
          send_varint(len, pick_width(len));
          send_varint(id, id_w);
        end
        1: begin
          dlen_w = pick_width(0);
          send_varint(dlen_w, pick_width(dlen_w));
          send_varint(0, dlen_w);
        end
        default: begin
          dlen_w = pick_width(0);
          len    = dlen_w + $urandom_range(1, id_w - 1);
          send_varint(len, pick_width(len));
          send_varint(0, dlen_w);
          send_varint(id, id_w);
        end
      endcase
    end else if (pick < 92) begin
      send_varint(0, pick_width(0));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(63)));
    end
    resync_stream();
  endtask

  task automatic test_plain_frames();
    send_byte(8'h03); send_byte(8'h01); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h80); send_byte(8'h00);
    send_byte(8'h05); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h80); send_byte(8'h01);
  endtask

  task automatic test_compressed_frames();
    write_mode(1'b1);
    send_byte(8'h02); send_byte(8'h05); send_byte(8'hAA);
    send_byte(8'h03); send_byte(8'h00); send_byte(8'h09); send_byte(8'h55);
    send_byte(8'h01); send_byte(8'h00);
  endtask

  // The frame format is fixed once its length is complete, so the rest stays compressed.
  task automatic test_mode_change_mid_frame();
    send_byte(8'h02);
    write_mode(1'b0);
    send_byte(8'h00); send_byte(8'h07);
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct);
    logic        flip;
    int unsigned start;
    flip          = 1'($urandom);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int seg = 0; seg < 2; seg++) begin
      write_mode(1'(seg) ^ flip);
      start = bytes_sent;
      while (bytes_sent - start < 70) begin
        send_random_frame();
        if ($urandom_range(24) == 0) wait_results_drained();
      end
    end
  endtask

  // A maximum frame length leaves the block inside the body, so this runs last.
  task automatic test_unbounded_length();
    write_mode(1'b0);
    send_varint(32'hFFFF_FFFF, VarintMaxBytes);
    send_byte(8'h00);
    send_payload(8);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_frames();
    test_compressed_frames();
    test_mode_change_mid_frame();
    test_random_traffic(19, 58);
    test_random_traffic(58, 19);
    test_random_traffic(0, 0);
    test_unbounded_length();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
